>>> rtl/ntcr_pkg.sv
// Shared types, constants and register map for the NTC resistance converter.
package ntcr_pkg;

    localparam int WORD_W           = 16;
    localparam int CODE_W           = 12;
    localparam int RES_W            = 16;
    localparam int REG_W            = 32;
    localparam int PROD_W           = 2 * REG_W;
    localparam int SAMPLES_AVERAGED = 4;
    localparam int SUM_W            = CODE_W + $clog2(SAMPLES_AVERAGED);
    localparam int CNT_W            = (SAMPLES_AVERAGED > 1) ? $clog2(SAMPLES_AVERAGED) : 1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int DIV_STEPS = RES_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SLOPE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_SLOPE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd4;

    localparam logic [REG_W-1:0] RST_NUM_SLOPE  = 32'd430001;
    localparam logic [REG_W-1:0] RST_NUM_OFFSET = 32'd1298330220;
    localparam logic [REG_W-1:0] RST_DEN_OFFSET = 32'd540970925;
    localparam logic [REG_W-1:0] RST_DEN_SLOPE  = 32'd49305;
    localparam logic [REG_W-1:0] RST_SCALE      = 32'd10000;

    localparam logic [RES_W-1:0] RES_MAX = '1;

    typedef struct packed {
        logic [REG_W-1:0] num_slope;
        logic [REG_W-1:0] num_offset;
        logic [REG_W-1:0] den_offset;
        logic [REG_W-1:0] den_slope;
        logic [REG_W-1:0] scale;
    } t_cfg;

    typedef struct packed {
        logic              push;
        logic [CODE_W-1:0] data;
    } t_push;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_PROD,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

>>> rtl/ntcr_front.sv
// Front end: clamps and scales ADC words, accumulates them, emits averages.
module ntcr_front
    import ntcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [WORD_W-1:0] i_adc_word,
    input  logic              i_full,
    output t_push             o_push
);

    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CODE_W-1:0] code;
    logic [SUM_W-1:0]  sum_acc;
    logic              accept;
    logic              last;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    // negative words clamp to zero
    assign code    = i_adc_word[WORD_W-1] ? '0 : i_adc_word[WORD_W-1 -: CODE_W];
    assign sum_acc = r_sum + SUM_W'(code);
    assign last    = (r_cnt == CNT_W'(SAMPLES_AVERAGED - 1));

    always_comb begin
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        o_push.push = 1'b0;
        o_push.data = CODE_W'(sum_acc / SUM_W'(SAMPLES_AVERAGED));
        if (accept) begin
            if (last) begin
                n_sum       = '0;
                n_cnt       = '0;
                o_push.push = 1'b1;
            end else begin
                n_sum = sum_acc;
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/ntcr_fifo.sv
// Short queue of averaged codes between the front end and the converter.
module ntcr_fifo
    import ntcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [CODE_W-1:0] o_data
);

    logic [CODE_W-1:0]     mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  do_push, do_pop;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = mem[r_rd_ptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/ntcr_back.sv
// Back end: numerator/denominator, 64-bit product and saturating division.
module ntcr_back
    import ntcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_empty,
    input  logic [CODE_W-1:0] i_avg,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [RES_W-1:0]  o_resistance,
    output logic [CODE_W-1:0] o_average_code,
    output logic              o_overflow
);

    t_back_state r_state, n_state;

    logic [CODE_W-1:0]    r_avg;
    logic [REG_W-1:0]     r_na, r_da;
    logic [REG_W-1:0]     r_num, r_den;
    logic [PROD_W-1:0]    r_prod;
    logic [REG_W-1:0]     r_rem;
    logic [RES_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_step;
    logic                 r_ovf;
    logic                 r_out_valid;
    logic [RES_W-1:0]     r_out_res;
    logic [CODE_W-1:0]    r_out_avg;
    logic                 r_out_ovf;

    logic                 load_out;
    logic [REG_W:0]       trial;
    logic [REG_W:0]       trial_diff;
    logic                 trial_ge;
    logic                 too_big;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial      = {r_rem, r_quo[RES_W-1]};
    assign trial_diff = trial - {1'b0, r_den};
    assign trial_ge   = (trial >= {1'b0, r_den});
    // quotient fits in RES_W bits only if prod < den * 2^RES_W
    assign too_big    = (r_prod[PROD_W-1:RES_W] >= (PROD_W - RES_W)'(r_den));

    assign o_valid        = r_out_valid;
    assign o_resistance   = r_out_res;
    assign o_average_code = r_out_avg;
    assign o_overflow     = r_out_ovf;

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_PROD;
            ST_PROD:  n_state = ST_CHECK;
            ST_CHECK: n_state = (r_ovf || too_big) ? ST_DONE : ST_DIV;
            ST_DIV: begin
                if (r_step == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_avg <= i_avg;
            end
            ST_MUL: begin
                r_na <= i_cfg.num_slope * REG_W'(r_avg);
                r_da <= i_cfg.den_slope * REG_W'(r_avg);
            end
            ST_SUM: begin
                r_num <= r_na + i_cfg.num_offset;
                r_den <= i_cfg.den_offset - r_da;
            end
            ST_PROD: begin
                r_prod <= PROD_W'(r_num) * PROD_W'(i_cfg.scale);
                r_ovf  <= (r_den == '0);
            end
            ST_CHECK: begin
                r_ovf  <= r_ovf || too_big;
                r_rem  <= r_prod[RES_W +: REG_W];
                r_quo  <= r_prod[RES_W-1:0];
                r_step <= '0;
            end
            ST_DIV: begin
                // r_quo holds the remaining dividend bits, quotient bits enter at the bottom
                r_rem  <= trial_ge ? trial_diff[REG_W-1:0] : trial[REG_W-1:0];
                r_quo  <= {r_quo[RES_W-2:0], trial_ge};
                r_step <= r_step + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_res <= r_ovf ? RES_MAX : r_quo;
            r_out_avg <= r_avg;
            r_out_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

>>> rtl/ntc_adc_average_to_resistance_top.sv
// Top level: configuration registers, front end, queue and converter.
//
// Each accepted ADC word is clamped (negative words count as zero), cut to a
// 12-bit code and added to a running sum; every fourth word closes a group
// and its truncated average enters a two-entry queue. The input side takes
// one word per cycle as long as that queue has room. The converter pops one
// average at a time and works through its steps in order: it loads the
// average, takes three steps for the multiply, the add and the 32x32
// product, checks the range, then runs a one-bit-per-cycle restoring
// divider (skipped when the divisor is zero or the quotient is known to
// exceed 16 bits, which saturates to 65535 with the overflow flag) and
// finally moves the result into the output register once the output is
// free. Registers are written through the plain write port and should only
// change while the block is idle.
module ntc_adc_average_to_resistance_top
    import ntcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WORD_W-1:0]    i_adc_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [RES_W-1:0]     o_resistance,
    output logic [CODE_W-1:0]    o_average_code,
    output logic                 o_overflow
);

    t_cfg              r_cfg;
    t_push             push;
    logic              fifo_full;
    logic              fifo_empty;
    logic              pop;
    logic [CODE_W-1:0] fifo_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_slope  <= RST_NUM_SLOPE;
            r_cfg.num_offset <= RST_NUM_OFFSET;
            r_cfg.den_offset <= RST_DEN_OFFSET;
            r_cfg.den_slope  <= RST_DEN_SLOPE;
            r_cfg.scale      <= RST_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_SLOPE:  r_cfg.num_slope  <= i_cfg_data;
                CFG_NUM_OFFSET: r_cfg.num_offset <= i_cfg_data;
                CFG_DEN_OFFSET: r_cfg.den_offset <= i_cfg_data;
                CFG_DEN_SLOPE:  r_cfg.den_slope  <= i_cfg_data;
                CFG_SCALE:      r_cfg.scale      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ntcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_adc_word (i_adc_word),
        .i_full     (fifo_full),
        .o_push     (push)
    );

    ntcr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_empty (fifo_empty),
        .o_data  (fifo_data)
    );

    ntcr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_empty        (fifo_empty),
        .i_avg          (fifo_data),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_resistance   (o_resistance),
        .o_average_code (o_average_code),
        .o_overflow     (o_overflow)
    );

endmodule

>>> sim/tb_ntc_adc_average_to_resistance_top.sv
// Self-checking testbench for the NTC averaging ADC-to-resistance converter.
module tb_ntc_adc_average_to_resistance_top;
    import ntcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic [RES_W-1:0]  resistance;
        logic [CODE_W-1:0] avg_code;
        logic              overflow;
    } t_conversion;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_RARE_STALL,
        RX_PERIODIC
    } t_rx_mode;

    // Tracks averaging state and register copies; queues expected conversions.
    class resistance_scoreboard;
        t_cfg              regs;
        logic [SUM_W-1:0]  code_sum;
        int unsigned       codes_seen;
        t_conversion       expected_q[$];
        int unsigned       mismatches;

        function new();
            regs.num_slope  = RST_NUM_SLOPE;
            regs.num_offset = RST_NUM_OFFSET;
            regs.den_offset = RST_DEN_OFFSET;
            regs.den_slope  = RST_DEN_SLOPE;
            regs.scale      = RST_SCALE;
            code_sum        = '0;
            codes_seen      = 0;
            mismatches      = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
            case (idx)
                CFG_NUM_SLOPE:  regs.num_slope  = data;
                CFG_NUM_OFFSET: regs.num_offset = data;
                CFG_DEN_OFFSET: regs.den_offset = data;
                CFG_DEN_SLOPE:  regs.den_slope  = data;
                CFG_SCALE:      regs.scale      = data;
                default: ;
            endcase
        endfunction

        function void note_word(logic [WORD_W-1:0] w);
            logic [CODE_W-1:0] code;
            logic [CODE_W-1:0] avg;
            logic [REG_W-1:0]  num;
            logic [REG_W-1:0]  den;
            logic [PROD_W-1:0] prod;
            logic [PROD_W-1:0] quo;
            t_conversion       c;
            // negative words clamp to zero
            code = w[WORD_W-1] ? '0 : w[WORD_W-1 -: CODE_W];
            code_sum += SUM_W'(code);
            codes_seen++;
            if (codes_seen < SAMPLES_AVERAGED) return;
            avg        = CODE_W'(code_sum / SAMPLES_AVERAGED);
            code_sum   = '0;
            codes_seen = 0;
            num  = regs.num_slope * REG_W'(avg) + regs.num_offset;
            den  = regs.den_offset - regs.den_slope * REG_W'(avg);
            prod = PROD_W'(num) * PROD_W'(regs.scale);
            c.avg_code = avg;
            if (den == '0) begin
                c.resistance = '1;
                c.overflow   = 1'b1;
            end else begin
                quo = prod / PROD_W'(den);
                if (quo > PROD_W'({RES_W{1'b1}})) begin
                    c.resistance = '1;
                    c.overflow   = 1'b1;
                end else begin
                    c.resistance = quo[RES_W-1:0];
                    c.overflow   = 1'b0;
                end
            end
            expected_q.push_back(c);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [RES_W-1:0] res, logic [CODE_W-1:0] avg, logic ovf);
            t_conversion e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result res=%0d avg=%0d ovf=%0b", res, avg, ovf));
                return;
            end
            e = expected_q.pop_front();
            if (res !== e.resistance)
                report($sformatf("resistance %0d, want %0d", res, e.resistance));
            if (avg !== e.avg_code)
                report($sformatf("average_code %0d, want %0d", avg, e.avg_code));
            if (ovf !== e.overflow)
                report($sformatf("overflow %0b, want %0b", ovf, e.overflow));
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [REG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [WORD_W-1:0]    i_adc_word;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [RES_W-1:0]     o_resistance;
    logic [CODE_W-1:0]    o_average_code;
    logic                 o_overflow;

    resistance_scoreboard conv = new();

    int       burst_left  = 0;
    int       idle_cycles = 0;
    t_rx_mode rx_mode     = RX_FREE;
    int       rx_left     = 0;
    logic [3:0] rx_phase  = '0;

    ntc_adc_average_to_resistance_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_adc_word     (i_adc_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_resistance   (o_resistance),
        .o_average_code (o_average_code),
        .o_overflow     (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: switches at random between stall patterns.
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:       i_ready <= 1'b1;
            RX_COIN:       i_ready <= $urandom_range(0, 1);
            RX_RARE_STALL: i_ready <= ($urandom_range(0, 7) != 0);
            RX_PERIODIC:   i_ready <= (rx_phase < 4'd3);
            default:       i_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            conv.check_result(o_resistance, o_average_code, o_overflow);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_ntc_adc_average_to_resistance_top NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [WORD_W-1:0] pick_adc_word();
        case ($urandom_range(0, 9))
            0:       return WORD_W'($urandom_range(0, 16'h001F));
            1:       return WORD_W'($urandom_range(16'h8000, 16'hFFFF));
            2:       return WORD_W'($urandom_range(16'h7FE0, 16'h7FFF));
            3:       return WORD_W'($urandom());
            default: return WORD_W'($urandom_range(0, 16'h7FFF));
        endcase
    endfunction

    // Valid stays high across a burst; gaps only between bursts.
    task automatic send_word(input logic [WORD_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_adc_word <= w;
        do @(posedge i_clk); while (!o_ready);
        conv.note_word(w);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_word(pick_adc_word());
    endtask

    // Drain expected conversions and let the converter settle before writes.
    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (conv.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        conv.set_register(idx, data);
    endtask

    task automatic load_settings(input t_cfg s, input bit with_unused);
        write_reg(CFG_NUM_SLOPE,  s.num_slope);
        write_reg(CFG_NUM_OFFSET, s.num_offset);
        write_reg(CFG_DEN_OFFSET, s.den_offset);
        write_reg(CFG_DEN_SLOPE,  s.den_slope);
        write_reg(CFG_SCALE,      s.scale);
        // indexes past the map must be ignored
        if (with_unused)
            for (int k = CFG_SCALE + 1; k < 2 ** CFG_IDX_W; k++)
                write_reg(CFG_IDX_W'(k), '1);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_cfg s;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_adc_word  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: zero, full-scale, negative words, truncating average
        repeat (4) send_word(16'h0000);
        repeat (4) send_word(16'h7FFF);
        send_word(16'h8000);
        send_word(16'hFFFF);
        send_word(16'h7FF0);
        send_word(16'h000F);
        send_word(16'hAAAA);
        send_word(16'h5555);
        send_word(16'h1234);
        send_word(16'hFFF0);
        send_random(300);

        // quotient right at the 16-bit limit, then one past it
        wait_idle();
        s = '{num_slope: 32'd1, num_offset: 32'd65535, den_offset: 32'd1,
              den_slope: 32'd0, scale: 32'd1};
        load_settings(s, 1'b0);
        repeat (4) send_word(16'h0000);
        repeat (3) send_word(16'h0000);
        send_word(16'h0040);
        send_random(60);

        // divisor hits zero at an average of 1000
        wait_idle();
        s = '{num_slope: $urandom(), num_offset: $urandom(), den_offset: 32'd1000,
              den_slope: 32'd1, scale: $urandom()};
        load_settings(s, 1'b0);
        repeat (4) send_word(16'h3E80);
        send_random(80);

        wait_idle();
        load_settings('0, 1'b1);
        send_random(60);

        wait_idle();
        load_settings('1, 1'b0);
        send_random(80);

        repeat (3) begin
            wait_idle();
            s = '{num_slope: $urandom_range(0, 4000),
                  num_offset: $urandom_range(0, 32'h00FF_FFFF),
                  den_offset: $urandom(),
                  den_slope: $urandom_range(0, 100000),
                  scale: $urandom_range(1, 2000)};
            load_settings(s, 1'b0);
            send_random(120);
        end

        wait_idle();
        s = '{num_slope: $urandom(), num_offset: $urandom(), den_offset: $urandom(),
              den_slope: $urandom(), scale: $urandom()};
        load_settings(s, 1'b1);
        send_random(100);

        wait_idle();
        if (conv.mismatches == 0)
            $display("tb_ntc_adc_average_to_resistance_top OK");
        else
            $display("tb_ntc_adc_average_to_resistance_top NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/ntcr_pkg.sv
rtl/ntcr_front.sv
rtl/ntcr_fifo.sv
rtl/ntcr_back.sv
rtl/ntc_adc_average_to_resistance_top.sv
sim/tb_ntc_adc_average_to_resistance_top.sv
